// File: design/bbrd_pkg.sv
// Shared constants, codes and types of the boolean byte-RLE decoder.
package bbrd_pkg;

	// Sizing
	localparam int MAX_BITS   = 2048;
	localparam int WORD_BITS  = 64;
	localparam int CFG_W      = 12;
	localparam int CNT_W      = $clog2(MAX_BITS + 1);
	localparam int FILL_W     = $clog2(WORD_BITS) + 1;
	localparam int BYTE_BITS  = 8;
	localparam int RUN_W      = 8;
	localparam int RUN_BITS_W = RUN_W + 3;

	// Stream format
	localparam int LIT_THRESH  = 128;
	localparam int REPEAT_BIAS = 3;

	// Queue depths
	localparam int CMDQ_DEPTH = 4;
	localparam int RESQ_DEPTH = 2;

	// Work handed from the front to the back
	typedef enum logic [1:0] {
		OP_FLUSH = 2'd0,
		OP_BYTES = 2'd1,
		OP_FILL  = 2'd2
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [BYTE_BITS-1:0] value;
		logic [RUN_W-1:0]     run;
		logic                 fill_after;
		logic                 malformed;
	} cmd_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] bits_word;
		logic [FILL_W-1:0]    valid_bits;
		logic                 final_word;
		logic                 malformed;
	} res_t;

endpackage

// File: design/bbrd_front.sv
// Front end: accepts encoded bytes, tracks the parse and issues decode work.
module bbrd_front import bbrd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CNT_W-1:0]     limit,
	input  logic                 push,
	output logic                 full,
	input  logic [BYTE_BITS-1:0] in_byte,
	input  logic                 end_of_stream,
	output logic                 cmd_push,
	output cmd_t                 cmd,
	input  logic                 cmdq_full
);

	typedef enum logic [2:0] {
		MODE_HEADER  = 3'b001,
		MODE_LITERAL = 3'b010,
		MODE_REPEAT  = 3'b100
	} mode_t;

	mode_t                mode_q, mode_n;
	logic [RUN_W-1:0]     left_q, left_n;
	logic [CNT_W-1:0]     produced_q, produced_n;
	logic                 done_q, done_n;

	logic                 accept;
	logic                 at_limit;
	logic                 fin;
	logic [CNT_W-1:0]     k;
	logic [RUN_W-1:0]     run;
	logic [RUN_BITS_W-1:0] run_bits;

	assign full   = cmdq_full;
	assign accept = push && !cmdq_full;

	// bits still wanted, and the size of a pending repeat run
	assign at_limit = produced_q >= limit;
	assign k        = limit - produced_q;
	assign run      = left_q + RUN_W'(REPEAT_BIAS);
	assign run_bits = {run, 3'b000};

	// classify the byte and predict whether the stream finishes on it
	always_comb begin
		mode_n     = mode_q;
		left_n     = left_q;
		produced_n = produced_q;
		done_n     = done_q;
		fin        = 1'b0;
		cmd_push   = 1'b0;
		cmd        = '{op: OP_FLUSH, value: in_byte, run: RUN_W'(1),
			fill_after: end_of_stream, malformed: 1'b0};
		if (accept) begin
			if (done_q) begin
				// count reached earlier: bytes are dropped until end of stream
			end else if (at_limit) begin
				cmd_push = 1'b1;
				fin      = 1'b1;
			end else begin
				case (mode_q)
					MODE_LITERAL: begin
						cmd_push   = 1'b1;
						cmd.op     = OP_BYTES;
						fin        = 32'(k) <= 32'(BYTE_BITS);
						produced_n = produced_q + CNT_W'(BYTE_BITS);
						left_n     = left_q - RUN_W'(1);
						if (left_q == RUN_W'(1))
							mode_n = MODE_HEADER;
					end
					MODE_REPEAT: begin
						cmd_push   = 1'b1;
						cmd.op     = OP_BYTES;
						cmd.run    = run;
						fin        = 32'(run_bits) >= 32'(k);
						produced_n = produced_q + CNT_W'(run_bits);
						left_n     = '0;
						mode_n     = MODE_HEADER;
					end
					default: begin
						if (32'(in_byte) >= 32'(LIT_THRESH)) begin
							left_n = RUN_W'(9'd256 - 9'(in_byte));
							mode_n = MODE_LITERAL;
						end else begin
							left_n = in_byte;
							mode_n = MODE_REPEAT;
						end
						// header on the last byte: pad out with ones
						if (end_of_stream) begin
							cmd_push      = 1'b1;
							cmd.op        = OP_FILL;
							cmd.malformed = 32'(in_byte) < 32'(LIT_THRESH);
						end
					end
				endcase
			end
			// end of stream always finishes and clears the stream
			if (end_of_stream) begin
				mode_n     = MODE_HEADER;
				left_n     = '0;
				produced_n = '0;
				done_n     = 1'b0;
			end else if (fin) begin
				done_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_HEADER;
			left_q     <= '0;
			produced_q <= '0;
			done_q     <= 1'b0;
		end else begin
			mode_q     <= mode_n;
			left_q     <= left_n;
			produced_q <= produced_n;
			done_q     <= done_n;
		end
	end

endmodule

// File: design/bbrd_cmd_queue.sv
// Short command queue between the front end and the back end.
module bbrd_cmd_queue import bbrd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty
);

	localparam int PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CNT_QW = $clog2(CMDQ_DEPTH + 1);

	cmd_t              entry_q [CMDQ_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_wr, do_rd;

	assign full    = count_q == CNT_QW'(CMDQ_DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr)
			entry_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CNT_QW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CNT_QW'(1);
		end
	end

endmodule

// File: design/bbrd_back.sv
// Back end: packs bits into words, emits them; one step a cycle unless stalled.
module bbrd_back import bbrd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] limit,
	input  logic             cmd_empty,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	input  logic             res_full,
	output logic             res_push,
	output res_t             res
);

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_RUN  = 3'b010,
		BK_FILL = 3'b100
	} bk_state_t;

	bk_state_t             state_q, state_n;
	logic [WORD_BITS-1:0]  acc_q, acc_n;
	logic [FILL_W-2:0]     fill_q, fill_n;
	logic [CNT_W-1:0]      produced_q, produced_n;
	logic [BYTE_BITS-1:0]  val_q;
	logic [RUN_W-1:0]      run_q;
	logic                  fa_q, mal_q;

	op_t                   cur_op;
	logic [BYTE_BITS-1:0]  cur_value;
	logic [RUN_W-1:0]      cur_run, rem;
	logic                  cur_fa, cur_mal, go, last;

	logic [CNT_W-1:0]      k;
	logic [3:0]            take;
	logic [BYTE_BITS:0]    mask9;
	logic [FILL_W-1:0]     room, n_ones, new_fill;
	logic [WORD_BITS-1:0]  ins, new_acc;

	// pick the work in hand: the queue head when idle, else the held run or padding
	always_comb begin
		case (state_q)
			BK_RUN: begin
				cur_op    = OP_BYTES;
				cur_value = val_q;
				cur_run   = run_q;
				cur_fa    = fa_q;
				cur_mal   = 1'b0;
				go        = !res_full;
			end
			BK_FILL: begin
				cur_op    = OP_FILL;
				cur_value = val_q;
				cur_run   = run_q;
				cur_fa    = fa_q;
				cur_mal   = mal_q;
				go        = !res_full;
			end
			default: begin
				cur_op    = cmd.op;
				cur_value = cmd.value;
				cur_run   = cmd.run;
				cur_fa    = cmd.fill_after;
				cur_mal   = cmd.malformed;
				go        = !cmd_empty && !res_full;
			end
		endcase
	end

	assign cmd_pop = (state_q == BK_IDLE) && go;
	assign k       = limit - produced_q;
	assign rem     = cur_run - RUN_W'(1);

	// one byte step, or one word of ones padding, or a flush
	always_comb begin
		state_n    = state_q;
		acc_n      = acc_q;
		fill_n     = fill_q;
		produced_n = produced_q;
		res_push   = 1'b0;
		last       = 1'b0;
		take       = 4'(BYTE_BITS);
		mask9      = '0;
		room       = FILL_W'(WORD_BITS) - FILL_W'(fill_q);
		n_ones     = room;
		ins        = '0;
		new_acc    = acc_q;
		new_fill   = FILL_W'(fill_q);
		res        = '{bits_word: acc_q, valid_bits: FILL_W'(fill_q),
			final_word: 1'b1, malformed: 1'b0};
		if (go) begin
			case (cur_op)
				OP_BYTES: begin
					last = 32'(k) <= 32'(BYTE_BITS);
					if (last)
						take = k[3:0];
					mask9    = (9'd1 << take) - 9'd1;
					ins      = WORD_BITS'(cur_value & mask9[BYTE_BITS-1:0]) << fill_q;
					new_acc  = acc_q | ins;
					new_fill = FILL_W'(fill_q) + FILL_W'(take);
					res.bits_word  = new_acc;
					res.valid_bits = new_fill;
					res.final_word = last;
					if (last) begin
						res_push = 1'b1;
					end else if (new_fill == FILL_W'(WORD_BITS)) begin
						res_push = 1'b1;
						acc_n    = '0;
						fill_n   = '0;
					end else begin
						acc_n  = new_acc;
						fill_n = new_fill[FILL_W-2:0];
					end
					produced_n = produced_q + CNT_W'(take);
					if (!last) begin
						if (rem != '0)
							state_n = BK_RUN;
						else if (cur_fa)
							state_n = BK_FILL;
						else
							state_n = BK_IDLE;
					end
				end
				OP_FILL: begin
					last = 32'(k) <= 32'(room);
					if (last)
						n_ones = FILL_W'(k);
					ins      = ({WORD_BITS{1'b1}} >> (FILL_W'(WORD_BITS) - n_ones)) << fill_q;
					new_acc  = acc_q | ins;
					new_fill = FILL_W'(fill_q) + n_ones;
					res_push = 1'b1;
					res      = '{bits_word: new_acc, valid_bits: new_fill,
						final_word: last, malformed: last && cur_mal};
					acc_n      = '0;
					fill_n     = '0;
					produced_n = produced_q + CNT_W'(n_ones);
					state_n    = BK_FILL;
				end
				default: begin
					// count already reached: hand out the partial word
					last     = 1'b1;
					res_push = 1'b1;
				end
			endcase
			// the final word closes the stream
			if (last) begin
				acc_n      = '0;
				fill_n     = '0;
				produced_n = '0;
				state_n    = BK_IDLE;
			end
		end
	end

	// details of a run carried over from the queue head
	always_ff @(posedge clk) begin
		if (go) begin
			val_q <= cur_value;
			run_q <= rem;
			fa_q  <= cur_fa;
			mal_q <= cur_mal;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			acc_q      <= '0;
			fill_q     <= '0;
			produced_q <= '0;
		end else begin
			state_q    <= state_n;
			acc_q      <= acc_n;
			fill_q     <= fill_n;
			produced_q <= produced_n;
		end
	end

endmodule

// File: design/bbrd_res_queue.sv
// Result queue that drives the output side of the decoder.
module bbrd_res_queue import bbrd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  res_t wr_data,
	output logic full,
	input  logic rd_en,
	output res_t rd_data,
	output logic empty
);

	localparam int PTR_W  = $clog2(RESQ_DEPTH);
	localparam int CNT_QW = $clog2(RESQ_DEPTH + 1);

	res_t              entry_q [RESQ_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_wr, do_rd;

	assign full    = count_q == CNT_QW'(RESQ_DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr)
			entry_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(RESQ_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(RESQ_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CNT_QW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CNT_QW'(1);
		end
	end

endmodule

// File: design/boolean_byte_rle_decoder.sv
// Top level of the boolean byte-RLE decoder.
//
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------
// input    | push / full            | in_byte, end_of_stream
// result   | pop / empty            | bits_word, valid_bits, final_word, malformed
// config   | cfg_valid / cfg_ready  | cfg_data (bit_count)
//
// Header and literal bytes are taken one per cycle; the front end stalls only when
// its four-entry command queue is full. The back end packs a repeat byte's run of
// header + 3 data bytes (up to 130) one byte per cycle while the result queue has
// room, and pads the end of a stream with 64-bit words of ones. Results leave
// through a two-entry queue, so a stalled pop holds up the back end only once that
// queue is full. Reset is asynchronous and takes effect at once; no clearing pass.
module boolean_byte_rle_decoder import bbrd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [BYTE_BITS-1:0] in_byte,
	input  logic                 end_of_stream,
	output logic                 empty,
	input  logic                 pop,
	output logic [WORD_BITS-1:0] bits_word,
	output logic [FILL_W-1:0]    valid_bits,
	output logic                 final_word,
	output logic                 malformed,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] bit_count_q;
	logic [31:0]      cfg_ext;
	logic [CNT_W-1:0] limit;

	cmd_t cmd_in, cmd_head;
	logic cmd_push, cmdq_full, cmd_pop, cmd_empty;
	res_t res_in, res_head;
	logic res_push, res_full;

	// configuration register; the limit taken from it saturates at the largest count
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bit_count_q <= '0;
		else if (cfg_valid && cfg_ready)
			bit_count_q <= cfg_data;
	end

	assign cfg_ext = 32'(bit_count_q);
	assign limit   = (cfg_ext > 32'(MAX_BITS)) ? CNT_W'(MAX_BITS) : CNT_W'(cfg_ext);

	bbrd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.limit         (limit),
		.push          (push),
		.full          (full),
		.in_byte       (in_byte),
		.end_of_stream (end_of_stream),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in),
		.cmdq_full     (cmdq_full)
	);

	bbrd_cmd_queue u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmdq_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.empty   (cmd_empty)
	);

	bbrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (limit),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	bbrd_res_queue u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_head),
		.empty   (empty)
	);

	assign bits_word  = res_head.bits_word;
	assign valid_bits = res_head.valid_bits;
	assign final_word = res_head.final_word;
	assign malformed  = res_head.malformed;

endmodule

// File: design/bbrd_checker.sv
// Port-level checks of the decoder, bound to the top level.
module bbrd_checker import bbrd_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 empty,
	input logic                 pop,
	input logic [WORD_BITS-1:0] bits_word,
	input logic [FILL_W-1:0]    valid_bits,
	input logic                 final_word,
	input logic                 malformed
);

	// a word that is not the last of its stream is always full
	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !final_word |-> valid_bits == FILL_W'(WORD_BITS))
		else $error("non-final word is not full");

	// bits above the valid count are zero, and the count never exceeds a word
	a_clean_top: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (valid_bits <= FILL_W'(WORD_BITS)) && ((bits_word >> valid_bits) == '0))
		else $error("bits above valid_bits are set");

	// malformed is only reported on the closing word
	a_mal_final: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && malformed |-> final_word)
		else $error("malformed flag on a non-final word");

	// a waiting result stays put until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(bits_word) && $stable(valid_bits)
			&& $stable(final_word) && $stable(malformed))
		else $error("waiting result changed");

endmodule

bind boolean_byte_rle_decoder bbrd_checker u_bbrd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.bits_word  (bits_word),
	.valid_bits (valid_bits),
	.final_word (final_word),
	.malformed  (malformed)
);
